// File: design/aesd_pkg.sv
// ----------------------------------------------------------------------------
// aesd_pkg: shared types and tables for the AES block decrypt core
// Holds the S-box tables, register codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package aesd_pkg;

  localparam int MaxWords = 60;
  localparam int NumCols  = 4;
  localparam int KeyRows  = MaxWords / NumCols;
  localparam int RowW     = $clog2(KeyRows);
  localparam int CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_BITS_0 = 3'd0,
    REG_KEY_BITS_1 = 3'd1,
    REG_KEY_BITS_2 = 3'd2,
    REG_KEY_BITS_3 = 3'd3,
    REG_KEY_SIZE   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_EXPAND,
    ST_IDLE,
    ST_KEY0,
    ST_ROUND,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic exp_init;
    logic exp_step;
    logic blk_load;
    logic blk_key0;
    logic blk_round;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic exp_last;
    logic rnd_last;
    logic out_busy;
  } sts_t;

  // byte x sits at bits {~x, 3'b000} +: 8 (entry 0 in the top byte)
  localparam logic [2047:0] SBOX = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] INV_SBOX = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    return INV_SBOX[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// File: design/aesd_ctrl.sv
// ----------------------------------------------------------------------------
// aesd_ctrl: sequencing for key expansion and block decryption
// Steps the datapath through expansion, initial key add, rounds and output.
// ----------------------------------------------------------------------------
module aesd_ctrl import aesd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:   state_d = ST_EXPAND;
      ST_EXPAND: if (sts_i.exp_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_KEY0;
      ST_KEY0:   state_d = ST_ROUND;
      ST_ROUND:  if (sts_i.rnd_last) state_d = ST_DONE;
      ST_DONE:   if (!sts_i.out_busy) state_d = ST_IDLE;
      default:   state_d = ST_INIT;
    endcase
    // restart the schedule on any key write
    if (cfg_we_i) state_d = ST_INIT;
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT:   cmd_o.exp_init = 1'b1;
      ST_EXPAND: cmd_o.exp_step = 1'b1;
      ST_IDLE: begin
        // hold off a request that meets a key write
        in_ready_o     = !cfg_we_i;
        cmd_o.blk_load = in_valid_i && !cfg_we_i;
      end
      ST_KEY0:   cmd_o.blk_key0  = 1'b1;
      ST_ROUND:  cmd_o.blk_round = 1'b1;
      ST_DONE:   cmd_o.out_load  = !sts_i.out_busy;
      default:   cmd_o = '0;
    endcase
  end

endmodule

// File: design/aesd_datapath.sv
// ----------------------------------------------------------------------------
// aesd_datapath: key registers, schedule memory, round unit, output register
// Expands one schedule word per cycle and runs one cipher round per cycle.
// ----------------------------------------------------------------------------
module aesd_datapath import aesd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic [127:0]       in_blk_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [127:0]       out_blk_o
);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    logic [1:0]   src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = 2'(c - r);
        t[127 - 8 * (r + 4 * c) -: 8] = inv_sbox(s[127 - 8 * (r + 4 * int'(src)) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] a);
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] x9 [4];
    logic [7:0] xb [4];
    logic [7:0] xd [4];
    logic [7:0] xe [4];
    for (int k = 0; k < 4; k++) begin
      m2[k] = xt(a[31 - 8 * k -: 8]);
      m4[k] = xt(m2[k]);
      m8[k] = xt(m4[k]);
      x9[k] = m8[k] ^ a[31 - 8 * k -: 8];
      xb[k] = m8[k] ^ m2[k] ^ a[31 - 8 * k -: 8];
      xd[k] = m8[k] ^ m4[k] ^ a[31 - 8 * k -: 8];
      xe[k] = m8[k] ^ m4[k] ^ m2[k];
    end
    return {xe[0] ^ xb[1] ^ xd[2] ^ x9[3],
            x9[0] ^ xe[1] ^ xb[2] ^ xd[3],
            xd[0] ^ x9[1] ^ xe[2] ^ xb[3],
            xb[0] ^ xd[1] ^ x9[2] ^ xe[3]};
  endfunction

  // key registers
  logic [63:0] key_q [4];
  logic [1:0]  ksize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) key_q[k] <= '0;
      ksize_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_KEY_BITS_0: key_q[0] <= cfg_data_i;
        REG_KEY_BITS_1: key_q[1] <= cfg_data_i;
        REG_KEY_BITS_2: key_q[2] <= cfg_data_i;
        REG_KEY_BITS_3: key_q[3] <= cfg_data_i;
        REG_KEY_SIZE:   ksize_q  <= cfg_data_i[1:0];
        default:        ;
      endcase
    end
  end

  logic [1:0] kidx;
  logic [3:0] nr, nk;
  logic [5:0] total;

  assign kidx  = (ksize_q == 2'd3) ? 2'd2 : ksize_q;
  assign nr    = 4'd10 + {1'b0, kidx, 1'b0};
  assign nk    = nr - 4'd6;
  assign total = {4'(nr + 4'd1), 2'b00};

  // schedule expansion
  logic [5:0]  ei_q;
  logic [2:0]  em_q;
  logic [7:0]  rc_q;
  logic [31:0] win_q [8];
  logic [31:0] kw, tw, new_w;
  logic [2:0]  far_idx;
  logic        past_key;

  assign far_idx  = 3'(nk - 4'd1);
  assign past_key = ei_q >= {2'b00, nk};
  assign kw       = ei_q[0] ? key_q[ei_q[2:1]][31:0] : key_q[ei_q[2:1]][63:32];

  always_comb begin
    tw = win_q[0];
    if (em_q == 3'd0) begin
      tw = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rc_q, 24'h0};
    end else if (nk == 4'd8 && em_q == 3'd4) begin
      tw = sub_word(win_q[0]);
    end
    new_w = past_key ? (win_q[far_idx] ^ tw) : kw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ei_q <= '0;
      em_q <= '0;
      rc_q <= 8'h01;
    end else if (cmd_i.exp_init) begin
      ei_q <= '0;
      em_q <= '0;
      rc_q <= 8'h01;
    end else if (cmd_i.exp_step) begin
      ei_q <= ei_q + 6'd1;
      em_q <= (em_q == far_idx) ? 3'd0 : em_q + 3'd1;
      if (past_key && em_q == 3'd0) rc_q <= xt(rc_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_step) begin
      win_q[0] <= new_w;
      for (int k = 1; k < 8; k++) win_q[k] <= win_q[k-1];
    end
  end

  // schedule memory: one bank per column, one row per round key
  logic [31:0]     bank_q [NumCols][KeyRows];
  logic [31:0]     rk_q   [NumCols];
  logic [RowW-1:0] rd_row;
  logic            rd_en;
  logic [3:0]      rnd_q;

  assign rd_row = RowW'(cmd_i.blk_load ? nr : rnd_q - 4'd1);
  assign rd_en  = cmd_i.blk_load | cmd_i.blk_key0 | (cmd_i.blk_round & (rnd_q != 4'd0));

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_step && ei_q < 6'(MaxWords)) begin
      bank_q[ei_q[1:0]][ei_q[RowW+1:2]] <= new_w;
    end
    if (rd_en) begin
      for (int c = 0; c < NumCols; c++) rk_q[c] <= bank_q[c][rd_row];
    end
  end

  // round unit
  logic [127:0] blk_q, ss, rkw, mixed;

  assign rkw = {rk_q[0], rk_q[1], rk_q[2], rk_q[3]};
  assign ss  = inv_shift_sub(blk_q) ^ rkw;

  always_comb begin
    for (int c = 0; c < 4; c++) mixed[127 - 32 * c -: 32] = inv_mix_col(ss[127 - 32 * c -: 32]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
    end else if (cmd_i.blk_load) begin
      rnd_q <= nr;
    end else if (cmd_i.blk_key0 || (cmd_i.blk_round && rnd_q != 4'd0)) begin
      rnd_q <= rnd_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.blk_load) begin
      blk_q <= in_blk_i;
    end else if (cmd_i.blk_key0) begin
      blk_q <= blk_q ^ rkw;
    end else if (cmd_i.blk_round) begin
      blk_q <= (rnd_q == 4'd0) ? ss : mixed;
    end
  end

  // output register
  logic         out_valid_q;
  logic [127:0] out_blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_blk_q <= blk_q;
  end

  assign out_valid_o     = out_valid_q;
  assign out_blk_o       = out_blk_q;
  assign sts_o.exp_last  = ei_q == total - 6'd1;
  assign sts_o.rnd_last  = rnd_q == 4'd0;
  assign sts_o.out_busy  = out_valid_q & ~out_ready_i;

endmodule

// File: design/aes_block_decrypt_core.sv
// ----------------------------------------------------------------------------
// aes_block_decrypt_core: AES inverse cipher, 128/192/256-bit keys
// One ciphertext block in, one plaintext block out, blocks independent.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  ciphertext block
// m_axis    out  m_axis_tvalid / m_axis_tready  plaintext block
// cfg       in   cfg_valid_i / cfg_ready_o      register index and data
//
// A block is loaded, has the last round key added and then runs nr rounds
// (10, 12 or 14) on the single shared round unit, one round per cycle,
// before it moves to the output register. After reset and after every key
// write a setup step and then one schedule word per cycle follow, with
// s_axis_tready low; a request meeting a key write is held off.
// The output register holds a finished block while the next one is accepted;
// the finished block waits in the round unit until that register frees.
// ----------------------------------------------------------------------------
module aes_block_decrypt_core import aesd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [127:0]       s_axis_tdata,  // [63:0] cipher_hi, [127:64] cipher_lo
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [127:0]       m_axis_tdata   // [63:0] plain_hi, [127:64] plain_lo
);

  cmd_t         cmd;
  sts_t         sts;
  logic         cfg_we;
  logic [127:0] out_blk;

  // take every write; drop indexes past the register list
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && (cfg_index_i <= REG_KEY_SIZE);

  aesd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // byte 0 of the block is the top byte of cipher_hi
  aesd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_blk_i    ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_blk_o   (out_blk)
  );

  assign m_axis_tdata = {out_blk[63:0], out_blk[127:64]};

endmodule

// File: design/aesd_checker.sv
// ----------------------------------------------------------------------------
// aesd_assert: port-level checks for the AES block decrypt core
// Watches handshakes on the top-level ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module aesd_assert import aesd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [63:0]        cfg_data_i,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [127:0]       s_axis_tdata,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [127:0]       m_axis_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one block at a time
  a_one_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while a block is in flight");

  // a key write restarts the schedule
  a_cfg_expand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i <= REG_KEY_SIZE) |=> !s_axis_tready)
    else $error("request taken during schedule expansion");

endmodule

bind aes_block_decrypt_core aesd_assert u_aesd_assert (.*);
